>>> src/usvq_pkg.sv
// Shared constants, types and tables of the UV sphere vertex and quad generator.
package usvq_pkg;

  localparam int unsigned MAX_SEGMENTS  = 1024;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned DIV_STEPS     = 32;
  localparam int unsigned ST_STEPS      = 31;
  localparam int unsigned CORDIC_STEPS  = 20;
  localparam int unsigned CORDIC_LAT    = CORDIC_STEPS + 2;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [24:0] POS_LIMIT   = 25'sd16777215;

  localparam logic [23:0] RADIUS_RESET  = 24'd65536;
  localparam logic [10:0] SECTORS_RESET = 11'd36;
  localparam logic [10:0] STACKS_RESET  = 11'd18;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_SECTORS = 2'd1,
    CFG_STACKS  = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_e;

  // Quadrant of a phase, from its two top bits.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Fields that ride alongside the arithmetic.
  typedef struct packed {
    logic [23:0] radius;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [20:0] base;
    logic        upper;
    logic        lower;
  } side_t;

  // State of the two long divisions.
  typedef struct packed {
    side_t       side;
    logic [10:0] se_cnt;
    logic [10:0] st_cnt;
    logic [10:0] rem_i;
    logic [10:0] rem_j;
    logic [32:0] quo_i;
    logic [32:0] quo_j;
  } div_t;

  // Arc tangent of 2^-k as a phase (2^32 is one turn).
  function automatic logic signed [31:0] atan_turn(input int unsigned k);
    logic signed [31:0] v;
    case (k)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/usvq_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of a phase in Q4.30.
module usvq_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int unsigned N = usvq_pkg::CORDIC_STEPS;

  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [31:0] z_q [N+1];
  logic [1:0]         quad_q [N+1];
  logic               zero_q [N+1];

  // Entry stage: start on the gain-scaled unit vector within the first quadrant.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= usvq_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= {2'b00, phase_i[29:0]};
      quad_q[0] <= phase_i[31:30];
      zero_q[0] <= (phase_i[29:0] == 30'd0);
    end
  end

  // One micro-rotation per stage.
  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[k] >= 0) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - usvq_pkg::atan_turn(k);
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + usvq_pkg::atan_turn(k);
        end
        quad_q[k+1] <= quad_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  // Exit stage: exact axis for a phase on a quadrant boundary, then quadrant rotation.
  logic signed [33:0] bx, by, rx, ry;

  always_comb begin
    bx = zero_q[N] ? usvq_pkg::ONE_Q30 : x_q[N];
    by = zero_q[N] ? 34'sd0 : y_q[N];
    case (usvq_pkg::quad_e'(quad_q[N]))
      usvq_pkg::QUAD_1: begin
        rx = -by;
        ry = bx;
      end
      usvq_pkg::QUAD_2: begin
        rx = -bx;
        ry = -by;
      end
      usvq_pkg::QUAD_3: begin
        rx = by;
        ry = -bx;
      end
      default: begin
        rx = bx;
        ry = by;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= rx;
      sin_o <= ry;
    end
  end

endmodule

>>> src/uv_sphere_vertex_and_quad_generator_top.sv
// UV sphere vertex and quad generator: one grid point in, one vertex record out.
// Throughput: one beat per cycle; a 32-stage divider, two 22-stage CORDIC units and two
// multiply stages form one pipeline that advances whenever the output register is free.
// A stalled output holds the whole pipeline. Reset clears all valid bits and loads the
// default radius (1.0), 36 sectors and 18 stacks.
module uv_sphere_vertex_and_quad_generator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // stack_index[10:0], sector_index[21:11]
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[24:0], pos_y[49:25], pos_z[74:50], normal_x[90:75], normal_y[106:91],
  // normal_z[122:107], tex_u[139:123], tex_v[156:140], quad_base_index[177:157],
  // upper_triangle_valid[178], lower_triangle_valid[179]
  output logic [183:0] m_axis_tdata,
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  localparam int unsigned NDIV = usvq_pkg::DIV_STEPS;
  localparam int unsigned NCOR = usvq_pkg::CORDIC_LAT;
  localparam logic [10:0] MAX_SEG = 11'(usvq_pkg::MAX_SEGMENTS);

  // Helpers for the divider.
  function automatic logic div_bit(input logic [10:0] rem, input logic [10:0] d);
    return {rem, 1'b0} >= {1'b0, d};
  endfunction

  function automatic logic [10:0] div_rem(input logic [10:0] rem, input logic [10:0] d);
    logic [11:0] t;
    t = {rem, 1'b0};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[10:0];
  endfunction

  function automatic logic round_up(input logic [10:0] rem, input logic [10:0] d);
    return ({1'b0, rem} + {2'b00, d[10:1]}) >= {1'b0, d};
  endfunction

  function automatic logic signed [24:0] sat_pos(input logic signed [63:0] v);
    logic signed [63:0] lim;
    lim = 64'(usvq_pkg::POS_LIMIT);
    if (v > lim) return usvq_pkg::POS_LIMIT;
    if (v < -lim) return -usvq_pkg::POS_LIMIT;
    return v[24:0];
  endfunction

  // Rounds a Q30 value to Q15 and saturates it to 16 bits.
  function automatic logic signed [15:0] sat_norm(input logic signed [63:0] q30);
    logic signed [63:0] v;
    v = (q30 + 64'sd16384) >>> 15;
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic en;
  logic out_valid_q;

  // Configuration registers.
  logic [23:0] radius_q;
  logic [10:0] sectors_q, stacks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= usvq_pkg::RADIUS_RESET;
      sectors_q <= usvq_pkg::SECTORS_RESET;
      stacks_q  <= usvq_pkg::STACKS_RESET;
    end else if (cfg_valid_i) begin
      case (usvq_pkg::cfg_idx_e'(cfg_index_i))
        usvq_pkg::CFG_RADIUS:  radius_q  <= cfg_data_i;
        usvq_pkg::CFG_SECTORS: sectors_q <= cfg_data_i[10:0];
        usvq_pkg::CFG_STACKS:  stacks_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together while the output register can take a beat.
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Entry stage: clamp counts and indices, quad flags and base index.
  logic [10:0] se_eff, st_eff, i_in, j_in, i_c, j_c;
  logic        qi0, qj0, quad;
  logic [21:0] base_full;
  usvq_pkg::div_t div_in;

  always_comb begin
    se_eff = (sectors_q < 11'd3) ? 11'd3 : ((sectors_q > MAX_SEG) ? MAX_SEG : sectors_q);
    st_eff = (stacks_q < 11'd2) ? 11'd2 : ((stacks_q > MAX_SEG) ? MAX_SEG : stacks_q);
    i_in   = s_axis_tdata[10:0];
    j_in   = s_axis_tdata[21:11];
    i_c    = (i_in > st_eff) ? st_eff : i_in;
    j_c    = (j_in > se_eff) ? se_eff : j_in;
    qi0    = (i_c == st_eff);
    qj0    = (j_c == se_eff);
    quad   = !qi0 && !qj0;
    base_full = {11'd0, i_c} * ({11'd0, se_eff} + 22'd1) + {11'd0, j_c};

    div_in              = '0;
    div_in.side.radius  = radius_q;
    div_in.side.base    = base_full[20:0];
    div_in.side.upper   = quad && (i_c != 11'd0);
    div_in.side.lower   = quad && (i_c != st_eff - 11'd1);
    div_in.se_cnt       = se_eff;
    div_in.st_cnt       = st_eff;
    div_in.rem_i        = qi0 ? 11'd0 : i_c;
    div_in.rem_j        = qj0 ? 11'd0 : j_c;
    div_in.quo_i        = {32'd0, qi0};
    div_in.quo_j        = {32'd0, qj0};
  end

  usvq_pkg::div_t div_q [NDIV+1];
  logic           v_div_q [NDIV+1];

  always_ff @(posedge clk_i) begin
    if (en) div_q[0] <= div_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_div_q[0] <= 1'b0;
    else if (en) v_div_q[0] <= s_axis_tvalid;
  end

  // Restoring division, one quotient bit per stage; texture values tapped midway.
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    usvq_pkg::div_t nxt;

    always_comb begin
      nxt       = div_q[k];
      nxt.quo_j = {div_q[k].quo_j[31:0], div_bit(div_q[k].rem_j, div_q[k].se_cnt)};
      nxt.rem_j = div_rem(div_q[k].rem_j, div_q[k].se_cnt);
      if (k < usvq_pkg::ST_STEPS) begin
        nxt.quo_i = {div_q[k].quo_i[31:0], div_bit(div_q[k].rem_i, div_q[k].st_cnt)};
        nxt.rem_i = div_rem(div_q[k].rem_i, div_q[k].st_cnt);
      end
      if (k == usvq_pkg::FRACTION_BITS - 1) begin
        nxt.side.tex_u = nxt.quo_j[16:0] + {16'd0, round_up(nxt.rem_j, nxt.se_cnt)};
        nxt.side.tex_v = nxt.quo_i[16:0] + {16'd0, round_up(nxt.rem_i, nxt.st_cnt)};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) div_q[k+1] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_div_q[k+1] <= 1'b0;
      else if (en) v_div_q[k+1] <= v_div_q[k];
    end
  end

  // Rounding stage: final phases of the stack and sector angles.
  logic [31:0]     st_phase_q, se_phase_q;
  usvq_pkg::side_t side_rnd_q;
  logic            v_rnd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_phase_q <= 32'h4000_0000 - (div_q[NDIV].quo_i[31:0] +
                    {31'd0, round_up(div_q[NDIV].rem_i, div_q[NDIV].st_cnt)});
      se_phase_q <= div_q[NDIV].quo_j[31:0] +
                    {31'd0, round_up(div_q[NDIV].rem_j, div_q[NDIV].se_cnt)};
      side_rnd_q <= div_q[NDIV].side;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_rnd_q <= 1'b0;
    else if (en) v_rnd_q <= v_div_q[NDIV];
  end

  // Sine and cosine of both angles.
  logic signed [33:0] cs, ss, cc, sc;

  usvq_cordic u_cordic_stack (
    .clk_i  (clk_i),
    .en_i   (en),
    .phase_i(st_phase_q),
    .cos_o  (cs),
    .sin_o  (ss)
  );

  usvq_cordic u_cordic_sector (
    .clk_i  (clk_i),
    .en_i   (en),
    .phase_i(se_phase_q),
    .cos_o  (cc),
    .sin_o  (sc)
  );

  usvq_pkg::side_t side_c_q [NCOR];
  logic            v_c_q [NCOR];

  for (genvar k = 0; k < NCOR; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) side_c_q[k] <= (k == 0) ? side_rnd_q : side_c_q[(k == 0) ? 0 : k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_c_q[k] <= 1'b0;
      else if (en) v_c_q[k] <= (k == 0) ? v_rnd_q : v_c_q[(k == 0) ? 0 : k-1];
    end
  end

  // First multiply stage: ring radius, z position and the normal products.
  logic signed [58:0] p_xy, p_z;
  logic signed [67:0] p_nx, p_ny;
  logic signed [26:0] xy_q;
  logic signed [24:0] pz_q;
  logic signed [35:0] nx_q, ny_q;
  logic signed [15:0] nz_q;
  logic signed [33:0] cc_q, sc_q;
  usvq_pkg::side_t    side_m_q;
  logic               v_m_q;

  always_comb begin
    p_xy = $signed({1'b0, side_c_q[NCOR-1].radius}) * cs;
    p_z  = $signed({1'b0, side_c_q[NCOR-1].radius}) * ss;
    p_nx = cs * cc;
    p_ny = cs * sc;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xy_q     <= 27'((p_xy + (59'sd1 <<< 29)) >>> 30);
      pz_q     <= sat_pos(64'((p_z + (59'sd1 <<< 29)) >>> 30));
      nx_q     <= 36'((p_nx + (68'sd1 <<< 29)) >>> 30);
      ny_q     <= 36'((p_ny + (68'sd1 <<< 29)) >>> 30);
      nz_q     <= sat_norm(64'(ss));
      cc_q     <= cc;
      sc_q     <= sc;
      side_m_q <= side_c_q[NCOR-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_m_q <= 1'b0;
    else if (en) v_m_q <= v_c_q[NCOR-1];
  end

  // Second multiply stage into the output register.
  logic signed [60:0] p_x, p_y;
  logic [183:0]       out_data_q;

  always_comb begin
    p_x = xy_q * cc_q;
    p_y = xy_q * sc_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q[24:0]    <= sat_pos(64'((p_x + (61'sd1 <<< 29)) >>> 30));
      out_data_q[49:25]   <= sat_pos(64'((p_y + (61'sd1 <<< 29)) >>> 30));
      out_data_q[74:50]   <= pz_q;
      out_data_q[90:75]   <= sat_norm(64'(nx_q));
      out_data_q[106:91]  <= sat_norm(64'(ny_q));
      out_data_q[122:107] <= nz_q;
      out_data_q[139:123] <= side_m_q.tex_u;
      out_data_q[156:140] <= side_m_q.tex_v;
      out_data_q[177:157] <= side_m_q.base;
      out_data_q[178]     <= side_m_q.upper;
      out_data_q[179]     <= side_m_q.lower;
      out_data_q[183:180] <= 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= v_m_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  // An accepted beat always occupies the first stage on the next edge.
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_div_q[0])
    else $error("accepted beat did not enter the pipeline");

  // The top row has v of zero and never carries an upper triangle.
  a_top_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[156:140] == 17'd0) |-> !m_axis_tdata[178])
    else $error("upper triangle flagged on the top row");

  // A stall freezes the first multiply stage's valid bit.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_m_q))
    else $error("pipeline moved during a stall");
`endif

endmodule
